@@ rtl/pcg32_pkg.sv @@
// ----------------------------------------------------------------------------
// pcg32_pkg: shared types, constants and helpers
// Holds the LCG constants, the XSH-RR output permutation and the sequencer
// state type for the PCG32 byte generator.
// ----------------------------------------------------------------------------
package pcg32_pkg;

   // LCG multiplier and output permutation constants
   localparam logic [63:0] LCG_MULT  = 64'd6364136223846793005;
   localparam int          XS_FIRST  = 18;
   localparam int          XS_SECOND = 27;
   localparam int          ROT_POS   = 59;

   // Field widths
   localparam int STATE_W     = 64;
   localparam int HALF_W      = 32;
   localparam int COUNT_W     = 7;
   localparam int WORD_W      = 32;
   localparam int BYTE_W      = 8;

   // Stream payload widths
   localparam int REQ_TDATA_W = 136;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 40;

   // Request kinds carried in req_tuser
   localparam logic REQ_SEED = 1'b0;
   localparam logic REQ_GET  = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED_GO,
      ST_SEED_WAIT,
      ST_SEED2_GO,
      ST_SEED2_WAIT,
      ST_GEN_GO,
      ST_GEN_WAIT
   } seq_state_type;

   // XSH-RR: xorshift high, then rotate right by the top five state bits
   function automatic logic [WORD_W-1:0] permute(input logic [STATE_W-1:0] s);
      logic [STATE_W-1:0]  xs;
      logic [WORD_W-1:0]   x;
      logic [4:0]          r;
      logic [2*WORD_W-1:0] dbl;
      xs  = (s >> XS_FIRST) ^ s;
      x   = xs[XS_SECOND +: WORD_W];
      r   = s[ROT_POS +: 5];
      dbl = {x, x} >> r;
      return dbl[WORD_W-1:0];
   endfunction

endpackage

@@ rtl/pcg32_step_unit.sv @@
// ----------------------------------------------------------------------------
// pcg32_step_unit: iterative LCG step
// Computes state * LCG_MULT + increment (mod 2^64) with one shared 32x32
// multiplier over three partial products. Result is valid on the done pulse.
// ----------------------------------------------------------------------------
module pcg32_step_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pcg32_pkg::STATE_W-1:0] state_val,
   input  logic [pcg32_pkg::STATE_W-1:0] incr_val,
   output logic                          busy,
   output logic                          done,
   output logic [pcg32_pkg::STATE_W-1:0] result
);
   import pcg32_pkg::*;

   logic [1:0]         phase_ff, phase_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STATE_W-1:0] prod_ff, prod_in;
   logic [STATE_W-1:0] acc_ff, acc_in;
   logic [HALF_W-1:0]  op_a, op_b;

   // operand select: lo*lo, then lo*hi, then hi*lo
   always_comb begin
      op_a = (phase_ff == 2'd2) ? state_val[STATE_W-1:HALF_W] : state_val[HALF_W-1:0];
      op_b = (phase_ff == 2'd1) ? LCG_MULT[STATE_W-1:HALF_W] : LCG_MULT[HALF_W-1:0];
   end

   // shared multiplier, product registered
   assign prod_in = op_a * op_b;

   // sequencing and accumulate
   always_comb begin
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      acc_in   = acc_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in  = 1'b1;
            phase_in = 2'd1;
         end
      end else begin
         case (phase_ff)
            2'd1: begin
               acc_in   = incr_val + prod_ff;
               phase_in = 2'd2;
            end
            2'd2: begin
               acc_in   = acc_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
               phase_in = 2'd3;
            end
            default: begin
               acc_in   = acc_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
               phase_in = 2'd0;
               busy_in  = 1'b0;
               done_in  = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign result = acc_ff;

`ifndef SYNTH
   // caller never starts a step while one is running
   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("step started while busy");
   // done follows the last phase and the unit is free by then
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff && phase_ff == 2'd0)
      else $error("done while busy");
   // a started step always finishes with a done pulse
   assert property (@(posedge clock) disable iff (reset) (start && !busy_ff) |-> ##4 done_ff)
      else $error("step latency wrong");
`endif

endmodule

@@ rtl/pcg32_byte_generator_unit.sv @@
// ----------------------------------------------------------------------------
// pcg32_byte_generator_unit: PCG32 (XSH-RR 64/32) random byte generator
// Usage:
//   req channel: tuser = request kind (seed or get). A seed item loads the
//   increment from init_seq, runs two LCG steps with init_state added in
//   between, and gives no result. A get item gives byte_count results
//   (saturated to MAX_BYTES, none for a count of zero).
//   rsp channel: one item per byte: the 32-bit output word of the state
//   before its step, its low byte, and tlast on the final byte of the run.
// Sequencing:
//   Each LCG step runs on one shared 32x32 multiplier over three partial
//   products; each byte takes a GEN_GO and a GEN_WAIT state, and GEN_GO
//   waits while the output register is full and stalled. A get item for N
//   bytes keeps req_tready low until its last step is done; rsp_tvalid
//   rises once GEN_GO has written the output register. A seed item keeps
//   req_tready low until both its steps are done; a get of count zero does not.
// Stalls: results sit in an output register; a stalled receiver holds the
//   next byte back, while the step for the current byte still proceeds.
// Reset: state clears to zero and the increment to one; no result pending.
// ----------------------------------------------------------------------------
module pcg32_byte_generator_unit #(
   parameter int MAX_BYTES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [63:0] init_state, [127:64] init_seq, [134:128] byte_count, [135] zero
   input  logic [pcg32_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] req_type
   input  logic [pcg32_pkg::REQ_TUSER_W-1:0] req_tuser,
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] rand_byte, [39:8] rand_word
   output logic [pcg32_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                              rsp_tlast
);
   import pcg32_pkg::*;

   localparam int CapInt = (MAX_BYTES > 127) ? 127 : MAX_BYTES;
   localparam logic [COUNT_W-1:0] CountCap = COUNT_W'(CapInt);

   seq_state_type      state_ff, state_in;
   logic [STATE_W-1:0] lcg_state_ff, lcg_state_in;
   logic [STATE_W-1:0] lcg_incr_ff, lcg_incr_in;
   logic [STATE_W-1:0] seed_add_ff, seed_add_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               req_fire;
   logic               out_free;
   logic               step_start;
   logic               step_busy;
   logic               step_done;
   logic [STATE_W-1:0] step_result;
   logic [COUNT_W-1:0] req_count;
   logic [COUNT_W-1:0] capped_count;
   logic [WORD_W-1:0]  cur_word;

   // request decode
   assign req_fire     = req_tvalid && req_tready;
   assign req_count    = req_tdata[2*STATE_W +: COUNT_W];
   assign capped_count = (req_count > CountCap) ? CountCap : req_count;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign cur_word     = permute(lcg_state_ff);

   // shared LCG step unit
   pcg32_step_unit u_step (
      .clock     (clock),
      .reset     (reset),
      .start     (step_start),
      .state_val (lcg_state_ff),
      .incr_val  (lcg_incr_ff),
      .busy      (step_busy),
      .done      (step_done),
      .result    (step_result)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser[0] == REQ_SEED) begin
                  state_in = ST_SEED_GO;
               end else if (capped_count != '0) begin
                  state_in = ST_GEN_GO;
               end
            end
         end
         ST_SEED_GO:    state_in = ST_SEED_WAIT;
         ST_SEED_WAIT:  if (step_done) state_in = ST_SEED2_GO;
         ST_SEED2_GO:   state_in = ST_SEED2_WAIT;
         ST_SEED2_WAIT: if (step_done) state_in = ST_IDLE;
         ST_GEN_GO:     if (out_free) state_in = ST_GEN_WAIT;
         ST_GEN_WAIT: begin
            if (step_done) begin
               state_in = (rem_ff == COUNT_W'(1)) ? ST_IDLE : ST_GEN_GO;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      step_start = 1'b0;
      unique case (state_ff)
         ST_IDLE:     req_tready = 1'b1;
         ST_SEED_GO:  step_start = 1'b1;
         ST_SEED2_GO: step_start = 1'b1;
         ST_GEN_GO:   step_start = out_free;
         default: begin
            req_tready = 1'b0;
            step_start = 1'b0;
         end
      endcase
   end

   // generator state, counter and output register
   always_comb begin
      lcg_state_in = lcg_state_ff;
      lcg_incr_in  = lcg_incr_ff;
      seed_add_in  = seed_add_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_tready) rsp_valid_in = 1'b0;

      if (req_fire) begin
         if (req_tuser[0] == REQ_SEED) begin
            lcg_state_in = '0;
            lcg_incr_in  = {req_tdata[STATE_W +: STATE_W-1], 1'b1};
            seed_add_in  = req_tdata[STATE_W-1:0];
         end else begin
            rem_in = capped_count;
         end
      end

      if (state_ff == ST_GEN_GO && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {cur_word, cur_word[BYTE_W-1:0]};
         rsp_last_in  = (rem_ff == COUNT_W'(1));
      end

      if (step_done) begin
         if (state_ff == ST_SEED_WAIT) begin
            lcg_state_in = step_result + seed_add_ff;
         end else begin
            lcg_state_in = step_result;
         end
         if (state_ff == ST_GEN_WAIT) rem_in = rem_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lcg_state_ff <= '0;
         lcg_incr_ff  <= STATE_W'(1);
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lcg_state_ff <= lcg_state_in;
         lcg_incr_ff  <= lcg_incr_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      seed_add_ff <= seed_add_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // the increment stays odd
   assert property (@(posedge clock) disable iff (reset) lcg_incr_ff[0])
      else $error("even LCG increment");
   // a run in progress always has bytes left
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GEN_GO || state_ff == ST_GEN_WAIT) |-> rem_ff != '0)
      else $error("byte run with zero count");
   // state only moves on a step result or a seed request
   assert property (@(posedge clock) disable iff (reset)
      (!step_done && !req_fire) |=> $stable(lcg_state_ff))
      else $error("LCG state changed without a step");
   // the step unit is idle whenever new requests are taken
   assert property (@(posedge clock) disable iff (reset) req_tready |-> !step_busy)
      else $error("request taken while stepping");
`endif

endmodule
